FILE: rtl/core/btpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_pkg: shared types and helpers for barometric compensation
// Request and response structs, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package btpc_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_OSS        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_PAIR_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_PAIR_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_PAIR_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_PAIR_D = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_PAIR_E = 3'd5;

	localparam logic CMD_TEMP  = 1'b0;
	localparam logic CMD_PRESS = 1'b1;

	localparam logic [31:0] TEMP_OFFSET = 32'd4000;
	localparam logic [31:0] B4_BIAS     = 32'd32768;
	localparam logic [31:0] B7_SCALE    = 32'd50000;
	localparam logic [31:0] P_C1        = 32'd3038;
	localparam logic [31:0] P_C2        = 32'hFFFF_E343; // -7357
	localparam logic [31:0] P_C3        = 32'd3791;

	typedef struct packed {
		logic        command;
		logic [23:0] raw_reading;
	} req_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [31:0] result_value;
		logic               divide_error;
	} rsp_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T_MUL,
		ST_T_DEN,
		ST_T_DIV,
		ST_P_B6,
		ST_P_SQ,
		ST_P_AC2,
		ST_P_B2,
		ST_P_AC3,
		ST_P_B1,
		ST_P_AC4,
		ST_P_B7,
		ST_P_DIVS,
		ST_P_DIVW,
		ST_P_SQP,
		ST_P_C1,
		ST_P_C2,
		ST_P_FIN,
		ST_OUT
	} state_t;

	function automatic logic [31:0] sra32(input logic [31:0] v, input logic [4:0] sh);
		sra32 = 32'($signed(v) >>> sh);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/btpc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_div: unsigned 32-bit restoring divider
// One quotient bit per cycle, done pulses once the quotient is ready.
// ----------------------------------------------------------------------------
module btpc_div
	import btpc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire div_req_t    req,
	output logic             done,
	output logic [31:0]      quotient
);

	logic        active_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] rem_sh;
	logic [32:0] diff;

	assign rem_sh = {rem_q[31:0], quo_q[31]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (active_q) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: rtl/core/baro_temp_pressure_compensation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation: integer temperature / pressure compensation
// Sequencer around one shared 32x32 multiplier and one serial divider.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  cmd     | cmd_valid, cmd_ready, cmd        | request in
//  rsp     | rsp_valid, rsp_ready, rsp        | response out
//  cfg     | cfg_valid, cfg_ready, cfg_index, | register write in
//          | cfg_data                         |
//
// a temperature request runs one multiplier pass, then the serial divider;
// a pressure request runs a chain of multiplier passes, the divider, then
// more multiplier passes; the divider yields 32 quotient bits and a done
// pulse, and each request ends in the output state
// reset puts oss to 0, calibration pairs to all ones, intermediate to 0
// cmd_ready is high only while the sequencer is idle; a finished result
// waits in the sequencer if the response register is still occupied
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation
	import btpc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	input  wire req_t                 cmd,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output rsp_t                      rsp,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	// configuration registers
	logic [1:0]  oss_q;
	logic [31:0] pair_a_q, pair_b_q, pair_c_q, pair_d_q, pair_e_q;
	// kept temperature intermediate (b5)
	logic [31:0] temp_q;

	state_t state_q, state_d;

	// datapath registers
	logic        kind_q;
	logic [23:0] raw_q;
	logic [31:0] prod_q;
	logic [31:0] x1_q;
	logic        neg_q;
	logic [31:0] b6_q, sq_q, xa_q, b3_q, b4_q, p_q;
	logic        half_q;
	logic [31:0] res_val_q;
	logic        res_err_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	// calibration fields
	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sx16(pair_a_q[31:16]);
	assign ac2 = sx16(pair_a_q[15:0]);
	assign ac3 = sx16(pair_b_q[31:16]);
	assign ac4 = {16'd0, pair_b_q[15:0]};
	assign ac5 = {16'd0, pair_c_q[31:16]};
	assign ac6 = {16'd0, pair_c_q[15:0]};
	assign b1  = sx16(pair_d_q[31:16]);
	assign b2  = sx16(pair_d_q[15:0]);
	assign mc  = sx16(pair_e_q[31:16]);
	assign md  = sx16(pair_e_q[15:0]);

	// shared multiplier, low 32 bits of the product
	logic [31:0] mul_a, mul_b;
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	div_req_t    div_req;
	logic        div_done;
	logic [31:0] div_quo;

	btpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// temperature divisor and numerator
	logic [31:0] t_x1, t_den, t_num, t_num_abs, t_den_abs;
	assign t_x1      = sra32(prod_q, 5'd15);
	assign t_den     = t_x1 + md;
	assign t_num     = mc << 11;
	assign t_num_abs = t_num[31] ? (32'd0 - t_num) : t_num;
	assign t_den_abs = t_den[31] ? (32'd0 - t_den) : t_den;

	// pressure intermediates
	logic [31:0] up, b7_scale_s, p_x3, p_b3_sum, t_q_signed, b5_new;
	assign up         = {8'd0, raw_q} >> (4'd8 - {2'd0, oss_q});
	assign b7_scale_s = B7_SCALE >> oss_q;
	assign p_x3       = sra32(xa_q + sra32(prod_q, 5'd16) + 32'd2, 5'd2);
	assign p_b3_sum   = ((ac1 << 2) + sra32(prod_q, 5'd11) + xa_q) << oss_q;
	assign t_q_signed = neg_q ? (32'd0 - div_quo) : div_quo;
	assign b5_new     = x1_q + t_q_signed;

	logic out_free;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid)
					state_d = (cmd.command == CMD_PRESS) ? ST_P_B6 : ST_T_MUL;
			end
			ST_T_MUL:  state_d = ST_T_DEN;
			ST_T_DEN:  state_d = (t_den == 32'd0) ? ST_OUT : ST_T_DIV;
			ST_T_DIV:  if (div_done) state_d = ST_OUT;
			ST_P_B6:   state_d = ST_P_SQ;
			ST_P_SQ:   state_d = ST_P_AC2;
			ST_P_AC2:  state_d = ST_P_B2;
			ST_P_B2:   state_d = ST_P_AC3;
			ST_P_AC3:  state_d = ST_P_B1;
			ST_P_B1:   state_d = ST_P_AC4;
			ST_P_AC4:  state_d = ST_P_B7;
			ST_P_B7:   state_d = ST_P_DIVS;
			ST_P_DIVS: state_d = (b4_q == 32'd0) ? ST_OUT : ST_P_DIVW;
			ST_P_DIVW: if (div_done) state_d = ST_P_SQP;
			ST_P_SQP:  state_d = ST_P_C1;
			ST_P_C1:   state_d = ST_P_C2;
			ST_P_C2:   state_d = ST_P_FIN;
			ST_P_FIN:  state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// multiplier operands and divider start per step
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		div_req = '0;
		case (state_q)
			ST_T_MUL: begin
				mul_a = {16'd0, raw_q[15:0]} - ac6;
				mul_b = ac5;
			end
			ST_T_DEN: begin
				div_req.start    = (t_den != 32'd0);
				div_req.dividend = t_num_abs;
				div_req.divisor  = t_den_abs;
			end
			ST_P_SQ: begin
				mul_a = b6_q;
				mul_b = b6_q;
			end
			ST_P_AC2: begin
				mul_a = ac2;
				mul_b = b6_q;
			end
			ST_P_B2: begin
				mul_a = b2;
				mul_b = sq_q;
			end
			ST_P_AC3: begin
				mul_a = ac3;
				mul_b = b6_q;
			end
			ST_P_B1: begin
				mul_a = b1;
				mul_b = sq_q;
			end
			ST_P_AC4: begin
				mul_a = ac4;
				mul_b = p_x3 + B4_BIAS;
			end
			ST_P_B7: begin
				mul_a = up - b3_q;
				mul_b = b7_scale_s;
			end
			ST_P_DIVS: begin
				// b7 below half: (b7 << 1) / b4, else (b7 / b4) << 1
				div_req.start    = (b4_q != 32'd0);
				div_req.dividend = prod_q[31] ? prod_q : (prod_q << 1);
				div_req.divisor  = b4_q;
			end
			ST_P_SQP: begin
				mul_a = sra32(p_q, 5'd8);
				mul_b = sra32(p_q, 5'd8);
			end
			ST_P_C1: begin
				mul_a = prod_q;
				mul_b = P_C1;
			end
			ST_P_C2: begin
				mul_a = P_C2;
				mul_b = p_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			oss_q       <= '0;
			pair_a_q    <= '1;
			pair_b_q    <= '1;
			pair_c_q    <= '1;
			pair_d_q    <= '1;
			pair_e_q    <= '1;
			temp_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && out_free)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_OSS:        oss_q    <= cfg_data[1:0];
					REG_CAL_PAIR_A: pair_a_q <= cfg_data;
					REG_CAL_PAIR_B: pair_b_q <= cfg_data;
					REG_CAL_PAIR_C: pair_c_q <= cfg_data;
					REG_CAL_PAIR_D: pair_d_q <= cfg_data;
					REG_CAL_PAIR_E: pair_e_q <= cfg_data;
					default: ;
				endcase
			end
			// b5 is kept only on a good temperature divide
			if (state_q == ST_T_DIV && div_done)
				temp_q <= b5_new;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q <= cmd.command;
				raw_q  <= cmd.raw_reading;
			end
			ST_T_DEN: begin
				x1_q      <= t_x1;
				neg_q     <= t_num[31] ^ t_den[31];
				res_val_q <= '0;
				res_err_q <= (t_den == 32'd0);
			end
			ST_T_DIV: begin
				if (div_done)
					res_val_q <= sra32(b5_new + 32'd8, 5'd4);
			end
			ST_P_B6:  b6_q <= temp_q - TEMP_OFFSET;
			ST_P_AC2: sq_q <= sra32(prod_q, 5'd12);
			ST_P_B2:  xa_q <= sra32(prod_q, 5'd11);
			ST_P_AC3: b3_q <= sra32(p_b3_sum + 32'd2, 5'd2);
			ST_P_B1:  xa_q <= sra32(prod_q, 5'd13);
			ST_P_B7:  b4_q <= prod_q >> 15;
			ST_P_DIVS: begin
				half_q    <= prod_q[31];
				res_val_q <= '0;
				res_err_q <= (b4_q == 32'd0);
			end
			ST_P_DIVW: begin
				if (div_done)
					p_q <= half_q ? (div_quo << 1) : div_quo;
			end
			ST_P_C2:  xa_q <= sra32(prod_q, 5'd16);
			ST_P_FIN: begin
				res_val_q <= p_q + sra32(xa_q + sra32(prod_q, 5'd16) + P_C3, 5'd4);
				res_err_q <= 1'b0;
			end
			ST_OUT: begin
				if (out_free) begin
					rsp_q.result_kind  <= kind_q;
					rsp_q.result_value <= res_val_q;
					rsp_q.divide_error <= res_err_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
